>>> rtl/drc_pkg.sv
// Shared constants and types for the division receipt checker.
// No dependencies.
package drc_pkg;
  localparam logic [31:0] HDR_MAGIC   = 32'h3152_4E4C;
  localparam logic [7:0]  FMT_ONE     = 8'd1;
  localparam logic [63:0] ST_OK       = 64'd1;
  localparam logic [63:0] ST_DIVZERO  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ST_OVERFLOW = 64'hFFFF_FFFF_FFFF_FFFE;
  localparam logic [2:0]  OP_A = 3'd0;
  localparam logic [2:0]  OP_B = 3'd1;
  localparam logic [2:0]  OP_D = 3'd2;
  localparam logic [2:0]  OP_Q = 3'd3;
  localparam logic [2:0]  OP_R = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_CMP, ST_DONE
  } state_t;
endpackage

>>> rtl/drc_serial_mul.sv
// Bit-serial shift-add multiply-accumulate: prod = x*y + z, one multiplier bit per cycle.
// Depends on nothing but its parameter.
module drc_serial_mul #(
  parameter int W = 256
) (
  input  logic           clk,
  input  logic           load,
  input  logic [W-1:0]   x,
  input  logic [W-1:0]   y,
  input  logic [W-1:0]   z,
  output logic [2*W-1:0] prod,
  output logic           done
);
  logic [W-1:0]         mcand;
  logic [W-1:0]         mplier;
  logic [W:0]           acc_hi;
  logic [$clog2(W+1)-1:0] cnt;
  logic [W:0]           sum;

  assign sum = acc_hi + (mplier[0] ? {1'b0, mcand} : '0);

  // High half accumulates; low half fills from the multiplier shift register.
  // The addend z starts in the high half and lands in the low half after W shifts.
  always_ff @(posedge clk) begin
    if (load) begin
      mcand  <= x;
      mplier <= y;
      acc_hi <= {1'b0, z};
      cnt    <= '0;
    end else if (!done) begin
      mplier <= {sum[0], mplier[W-1:1]};
      acc_hi <= {1'b0, sum[W:1]};
      cnt    <= cnt + 1'b1;
    end
  end

  assign done = (cnt == ($clog2(W+1))'(W));
  assign prod = {acc_hi[W-1:0], mplier};
endmodule

>>> rtl/division_receipt_checker.sv
// Division receipt checker top level.
// Depends on drc_pkg and drc_serial_mul.
//
// Usage: drive an item with start high while busy is low. mode 0 loads one
// limb of operand a, b, d, q or r (operand_select, limb_index) and yields
// no result. mode 1 checks a claimed division outcome against n = a*b and
// yields one verdict on accepted, marked by a one-cycle strobe. A check
// runs two bit-serial multipliers (a*b and q*d + r run side by side, one
// bit a cycle) followed by a compare state. busy stays high through the
// strobe cycle; the next item can be taken in the cycle after the strobe.
// Loads sustain one per cycle while busy is low. Reset clears the operand
// store and control. The receiver cannot stall; the verdict is shown
// exactly once.
module division_receipt_checker #(
  parameter int LIMBS      = 4,
  parameter int LIMB_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [2:0]  operand_select,
  input  logic [1:0]  limb_index,
  input  logic [63:0] limb_value,
  input  logic [31:0] header_word,
  input  logic [7:0]  format_version,
  input  logic [7:0]  format_variant,
  input  logic signed [63:0] status_code,
  output logic        strobe,
  output logic        accepted
);
  import drc_pkg::*;

  localparam int W = LIMBS * LIMB_WIDTH;

  logic [W-1:0] opa, opb, opd, opq, opr;
  state_t state, state_next;
  logic   accept_item;
  logic   hdr_ok;
  logic [63:0] st_reg;
  logic   mul_load;
  logic [2*W-1:0] prod_n, prod_qd;
  logic   done_n, done_qd;
  logic   verdict;
  logic   verdict_reg;
  logic   lim_ok;
  logic [W-1:0] limb_mask_w;

  assign accept_item = start && !busy;
  assign lim_ok = (32'(limb_index) < LIMBS);
  assign limb_mask_w = W'({LIMB_WIDTH{1'b1}}) << (limb_index * LIMB_WIDTH);

  // Operand store: at most one limb written per load item.
  always_ff @(posedge clk) begin
    if (rst) begin
      opa <= '0; opb <= '0; opd <= '0; opq <= '0; opr <= '0;
    end else if (accept_item && !mode && lim_ok) begin
      case (operand_select)
        OP_A: opa <= (opa & ~limb_mask_w) |
                     ((W'(limb_value[LIMB_WIDTH-1:0])) << (limb_index * LIMB_WIDTH));
        OP_B: opb <= (opb & ~limb_mask_w) |
                     ((W'(limb_value[LIMB_WIDTH-1:0])) << (limb_index * LIMB_WIDTH));
        OP_D: opd <= (opd & ~limb_mask_w) |
                     ((W'(limb_value[LIMB_WIDTH-1:0])) << (limb_index * LIMB_WIDTH));
        OP_Q: opq <= (opq & ~limb_mask_w) |
                     ((W'(limb_value[LIMB_WIDTH-1:0])) << (limb_index * LIMB_WIDTH));
        OP_R: opr <= (opr & ~limb_mask_w) |
                     ((W'(limb_value[LIMB_WIDTH-1:0])) << (limb_index * LIMB_WIDTH));
        default: ;
      endcase
    end
  end

  // Latch header check and status of a check item.
  always_ff @(posedge clk) begin
    if (accept_item && mode) begin
      hdr_ok <= (header_word == HDR_MAGIC) && (format_version == FMT_ONE) &&
                (format_variant == FMT_ONE);
      st_reg <= status_code;
    end
  end

  assign mul_load = accept_item && mode;

  drc_serial_mul #(.W(W)) u_mul_ab (
    .clk(clk), .load(mul_load), .x(opa), .y(opb), .z('0), .prod(prod_n), .done(done_n)
  );
  drc_serial_mul #(.W(W)) u_mul_qd (
    .clk(clk), .load(mul_load), .x(opq), .y(opd), .z(opr), .prod(prod_qd),
    .done(done_qd)
  );

  // Final verdict, evaluated in the compare cycle.
  // q*d + r always fits in 2*W bits, so no carry out is possible.
  always_comb begin
    verdict = 1'b0;
    if (hdr_ok) begin
      case (st_reg)
        ST_DIVZERO:  verdict = (opd == '0);
        ST_OVERFLOW: verdict = (opd != '0) && (prod_n[2*W-1:W] >= opd);
        ST_OK:       verdict = (opd != '0) && (opr < opd) && (prod_qd == prod_n);
        default:     verdict = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == ST_CMP) verdict_reg <= verdict;
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (mul_load) state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: if (done_n && done_qd) state_next = ST_CMP;
      ST_CMP:  state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy     = (state != ST_IDLE);
  assign strobe   = (state == ST_DONE);
  assign accepted = verdict_reg;

`ifndef SYNTHESIS
  a_strobe_once: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe) else $error("verdict strobe repeated");
  a_busy_on_check: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode) |=> busy) else $error("check not started");
  a_no_strobe_load: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !mode) |=> !strobe) else $error("load gave result");
`endif
endmodule
